// File: hdl/nlkj_pkg.sv
// Package for the nested-loop key join engine: sizes, operation and result codes,
// and the command type passed from the front end to the execution unit.
// No dependencies.
package nlkj_pkg;

    localparam int BUILD_ROWS  = 64;
    localparam int KEY_W       = 64;
    localparam int ROW_W       = 6;
    localparam int RAM_DEPTH   = 1 << ROW_W;
    localparam int CNT_W       = ROW_W + 1;
    localparam int PROW_W      = 9;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int FILL_W      = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_PROBE  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_APPENDED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MATCHED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [KEY_W-1:0]  key;
        logic [PROW_W-1:0] probe_row;
    } cmd_t;

endpackage

// File: hdl/nlkj_if.sv
// Valid/ready channel interfaces for the join engine: the command channel and
// the result channel. Depends on nlkj_pkg.
interface nlkj_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [nlkj_pkg::OP_W-1:0]   opcode;
    logic [nlkj_pkg::KEY_W-1:0]  key;
    logic [nlkj_pkg::PROW_W-1:0] probe_row;

    modport source (output valid, output opcode, output key, output probe_row, input ready);
    modport sink   (input valid, input opcode, input key, input probe_row, output ready);
endinterface

interface nlkj_res_if;
    logic                         valid;
    logic                         ready;
    logic [nlkj_pkg::STATUS_W-1:0] status;
    logic [nlkj_pkg::PROW_W-1:0]   left_row;
    logic [nlkj_pkg::ROW_W-1:0]    right_row;
    logic                         last;

    modport source (output valid, output status, output left_row, output right_row,
                    output last, input ready);
    modport sink   (input valid, input status, input left_row, input right_row,
                    input last, output ready);
endinterface

// File: hdl/nlkj_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read port.
// Read data holds while no read is requested. No dependencies.
module nlkj_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/nlkj_front.sv
// Front end of the join engine: takes command transfers, drops the unused
// opcode and queues the rest for the execution unit. Depends on nlkj_pkg, nlkj_if.
module nlkj_front (
    input  logic            clk,
    input  logic            rst_n,
    nlkj_cmd_if.sink        cmd,
    output logic            q_valid,
    output nlkj_pkg::cmd_t  q_head,
    input  logic            q_pop
);

    nlkj_pkg::cmd_t                       entries_reg [nlkj_pkg::QUEUE_DEPTH];
    logic [nlkj_pkg::QUEUE_AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [nlkj_pkg::QUEUE_AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [nlkj_pkg::FILL_W-1:0]          fill_reg, fill_next;
    logic                                 push;
    logic                                 pop;

    // A transfer is taken whenever the queue has room; the unused opcode is
    // consumed without entering the queue.
    assign cmd.ready = (fill_reg != nlkj_pkg::FILL_W'(nlkj_pkg::QUEUE_DEPTH));
    assign push      = cmd.valid && cmd.ready && (cmd.opcode != nlkj_pkg::OP_NONE);
    assign pop       = q_pop && q_valid;

    assign q_valid = (fill_reg != '0);
    assign q_head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= '{opcode: cmd.opcode, key: cmd.key,
                                         probe_row: cmd.probe_row};
        end
    end

endmodule

// File: hdl/nlkj_back.sv
// Execution unit of the join engine: owns the build key store and row count,
// runs clear, append and probe scans, and drives the registered result channel.
// Depends on nlkj_pkg, nlkj_if and nlkj_ram.
module nlkj_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            join_mode,
    input  logic            q_valid,
    input  nlkj_pkg::cmd_t  q_head,
    output logic            q_pop,
    nlkj_res_if.source      res
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_SCAN = 1'b1;

    logic [0:0]                      state_reg, state_next;
    logic [nlkj_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [nlkj_pkg::CNT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic [nlkj_pkg::ROW_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [nlkj_pkg::ROW_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [nlkj_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [nlkj_pkg::PROW_W-1:0]     prow_reg, prow_next;

    logic                            out_valid_reg;
    logic [nlkj_pkg::STATUS_W-1:0]   out_status_reg;
    logic [nlkj_pkg::PROW_W-1:0]     out_left_reg;
    logic [nlkj_pkg::ROW_W-1:0]      out_right_reg;
    logic                            out_last_reg;

    logic                            emit;
    logic [nlkj_pkg::STATUS_W-1:0]   emit_status;
    logic [nlkj_pkg::PROW_W-1:0]     emit_left;
    logic [nlkj_pkg::ROW_W-1:0]      emit_right;
    logic                            emit_last;

    logic                            out_free;
    logic                            wr_en;
    logic                            rd_en;
    logic [nlkj_pkg::KEY_W-1:0]      rd_data;
    logic                            match;
    logic                            scan_done;

    nlkj_ram #(
        .WIDTH (nlkj_pkg::KEY_W),
        .DEPTH (nlkj_pkg::RAM_DEPTH)
    ) u_keys (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[nlkj_pkg::ROW_W-1:0]),
        .wr_data (q_head.key),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg[nlkj_pkg::ROW_W-1:0]),
        .rd_data (rd_data)
    );

    assign out_free  = !out_valid_reg || res.ready;
    assign match     = cmp_valid_reg && (rd_data == key_reg);
    assign scan_done = (scan_idx_reg == count_reg) && !cmp_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        key_next        = key_reg;
        prow_next       = prow_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        emit            = 1'b0;
        emit_status     = nlkj_pkg::ST_APPENDED;
        emit_left       = '0;
        emit_right      = '0;
        emit_last       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    unique case (q_head.opcode)
                        nlkj_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        nlkj_pkg::OP_APPEND:
                        begin
                            emit      = 1'b1;
                            emit_last = 1'b1;
                            if (count_reg < nlkj_pkg::CNT_W'(nlkj_pkg::BUILD_ROWS))
                            begin
                                wr_en       = 1'b1;
                                emit_status = nlkj_pkg::ST_APPENDED;
                                emit_right  = count_reg[nlkj_pkg::ROW_W-1:0];
                                count_next  = count_reg + 1'b1;
                            end
                            else
                            begin
                                emit_status = nlkj_pkg::ST_FULL;
                            end
                        end
                        nlkj_pkg::OP_PROBE:
                        begin
                            key_next        = q_head.key;
                            prow_next       = q_head.probe_row;
                            scan_idx_next   = '0;
                            cmp_valid_next  = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        default:
                        begin
                            // the front end never queues the unused opcode
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    // The held match, or the unmatched row in left mode, closes the probe.
                    if (pend_valid_reg)
                    begin
                        if (out_free)
                        begin
                            emit        = 1'b1;
                            emit_status = nlkj_pkg::ST_MATCHED;
                            emit_left   = prow_reg;
                            emit_right  = pend_idx_reg;
                            emit_last   = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    else if (join_mode)
                    begin
                        if (out_free)
                        begin
                            emit        = 1'b1;
                            emit_status = nlkj_pkg::ST_UNMATCHED;
                            emit_left   = prow_reg;
                            emit_last   = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (!(match && pend_valid_reg && !out_free))
                begin
                    rd_en          = (scan_idx_reg < count_reg);
                    cmp_valid_next = rd_en;
                    cmp_idx_next   = scan_idx_reg[nlkj_pkg::ROW_W-1:0];
                    if (rd_en)
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                    if (match)
                    begin
                        // A new match releases the previous one, which is then not last.
                        if (pend_valid_reg)
                        begin
                            emit        = 1'b1;
                            emit_status = nlkj_pkg::ST_MATCHED;
                            emit_left   = prow_reg;
                            emit_right  = pend_idx_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = cmp_idx_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        pend_idx_reg <= pend_idx_next;
        key_reg      <= key_next;
        prow_reg     <= prow_next;
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_left_reg   <= emit_left;
            out_right_reg  <= emit_right;
            out_last_reg   <= emit_last;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.status    = out_status_reg;
    assign res.left_row  = out_left_reg;
    assign res.right_row = out_right_reg;
    assign res.last      = out_last_reg;

endmodule

// File: hdl/nested_loop_key_join_core.sv
// An append's result appears in the cycle after it leaves the queue. A probe scans
// its stored keys one per cycle from the key memory while the result channel does not
// hold the scan back, and the execution unit takes no further command until the probe
// has finished its scan and issued any final result. Reset (rst_n, asynchronous,
// active low) empties the queue and the build table and selects inner join; the key
// memory itself is not cleared.
module nested_loop_key_join_core (
    input  logic        clk,
    input  logic        rst_n,
    nlkj_cmd_if.sink    cmd,
    nlkj_res_if.source  res,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    // The join mode register: 0 gives an inner join, 1 a left outer join in which
    // a probe that finds no equal key returns one unmatched-left result.
    logic           join_mode_reg;

    // Queue head presented by the front end to the execution unit.
    logic           q_valid;
    nlkj_pkg::cmd_t q_head;
    logic           q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            join_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            join_mode_reg <= cfg_wdata;
        end
    end

    // The front end takes a command transfer whenever its short queue has room, so
    // further commands keep arriving while a probe scan or a stalled result is
    // being worked through at the back.
    nlkj_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    // The execution unit holds each match back by one so that the final result of
    // a probe can carry the last flag, and it drives the result register.
    nlkj_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .join_mode (join_mode_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res       (res)
    );

endmodule

// File: verif/nested_loop_key_join_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for nested_loop_key_join_core: directed and random command
// streams, with every result transfer checked against a behavioural join predictor or a written expectation.
// Depends on nlkj_pkg, the nlkj_cmd_if / nlkj_res_if interfaces and the core itself.
module nested_loop_key_join_core_tb;

    // Any stretch longer than this without a single transfer on either channel is a hang.
    // The longest legal quiet stretch is the receiver hold-off (HOLD_CYCLES) or the
    // settling pause (QUIET_CYCLES), so this leaves ample margin.
    localparam int WATCHDOG_LIMIT = 2000;
    // After the last expected result, the engine may still be scanning inner probes that
    // emit nothing: two queued plus one executing, each scanning up to BUILD_ROWS stored keys.
    localparam int QUIET_CYCLES   = 3 * (nlkj_pkg::BUILD_ROWS + 3) + 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 330;
    localparam int MAX_PRINTS     = 50;

    typedef struct packed {
        logic [nlkj_pkg::STATUS_W-1:0] status;
        logic [nlkj_pkg::PROW_W-1:0]   left_row;
        logic [nlkj_pkg::ROW_W-1:0]    right_row;
        logic                          last;
    } result_t;

    // How a directed row is checked: against the predictor, as producing nothing, or
    // against the single result written into the row.
    typedef enum {CHECK_PREDICTED, CHECK_SILENT, CHECK_SINGLE} check_t;

    typedef struct {
        bit             outer;
        nlkj_pkg::cmd_t cmd;
        check_t         chk;
        result_t        want;
    } vector_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    nlkj_cmd_if cmd_ch();
    nlkj_res_if res_ch();

    nested_loop_key_join_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state: our own copy of the build table and of the join mode.
    logic [nlkj_pkg::KEY_W-1:0] stored_keys [nlkj_pkg::BUILD_ROWS];
    int               stored_n   = 0;
    bit               left_outer = 1'b0;

    result_t     step_results [$];
    result_t     pending_results [$];
    int unsigned mismatches  = 0;
    int unsigned items_sent  = 0;
    int unsigned quiet_count = 0;

    // Idling controls, set by the stimulus process; hold_served and hold_left are kept by the receiver.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_asks      = 0;
    int unsigned hold_served    = 0;
    int unsigned hold_left      = 0;

    vector_t directed [$];

    always #5 clk = ~clk;

    // One line per mismatch, with printing capped so that a badly broken design cannot
    // flood the log; every mismatch is still counted.
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    function automatic logic [nlkj_pkg::KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    function automatic vector_t vec(input bit outer, input logic [nlkj_pkg::OP_W-1:0] op,
                                    input logic [nlkj_pkg::KEY_W-1:0] key,
                                    input logic [nlkj_pkg::PROW_W-1:0] prow,
                                    input check_t chk,
                                    input logic [nlkj_pkg::STATUS_W-1:0] st =
                                        nlkj_pkg::ST_APPENDED,
                                    input logic [nlkj_pkg::PROW_W-1:0] lrow = '0,
                                    input logic [nlkj_pkg::ROW_W-1:0] rrow = '0);
        vector_t v;
        v.outer = outer;
        v.cmd   = '{op, key, prow};
        v.chk   = chk;
        v.want  = '{st, lrow, rrow, 1'b1};
        return v;
    endfunction

    // Works out the results of one accepted command and advances the predictor state.
    // A probe walks the stored keys in ascending row order, so matched pairs come out in
    // row order; only the final result of a command carries last.
    function automatic void predict_join(input nlkj_pkg::cmd_t c);
        result_t r;
        int      idx;
        step_results.delete();
        case (c.opcode)
            nlkj_pkg::OP_CLEAR:
                stored_n = 0;
            nlkj_pkg::OP_APPEND:
            begin
                if (stored_n < nlkj_pkg::BUILD_ROWS)
                begin
                    stored_keys[stored_n] = c.key;
                    r = '{nlkj_pkg::ST_APPENDED, '0, nlkj_pkg::ROW_W'(stored_n), 1'b1};
                    stored_n++;
                end
                else
                begin
                    // Table full: the key is dropped and the table is left as it was.
                    r = '{nlkj_pkg::ST_FULL, '0, '0, 1'b1};
                end
                step_results.push_back(r);
            end
            nlkj_pkg::OP_PROBE:
            begin
                for (idx = 0; idx < stored_n; idx++)
                begin
                    if (stored_keys[idx] == c.key)
                    begin
                        r = '{nlkj_pkg::ST_MATCHED, c.probe_row, nlkj_pkg::ROW_W'(idx), 1'b0};
                        step_results.push_back(r);
                    end
                end
                if (step_results.size() == 0 && left_outer)
                begin
                    // Left outer join: a probe without partner still yields its row,
                    // standing for the NULL columns of table 2.
                    r = '{nlkj_pkg::ST_UNMATCHED, c.probe_row, '0, 1'b1};
                    step_results.push_back(r);
                end
                else if (step_results.size() != 0)
                begin
                    step_results[step_results.size() - 1].last = 1'b1;
                end
            end
            default:
                ; // the unused opcode is ignored by the engine
        endcase
    endfunction

    // Offers one command, with random idle cycles in front of it, and waits for the
    // transfer. Valid is left high on return so that back-to-back commands never lower
    // and raise it within one time step.
    task automatic send_cmd(input nlkj_pkg::cmd_t c, input check_t chk, input result_t want);
        while ($urandom_range(1, 100) <= send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.opcode    <= c.opcode;
        cmd_ch.key       <= c.key;
        cmd_ch.probe_row <= c.probe_row;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        // The transfer has happened at this edge; the predictor always runs so that its
        // table follows the engine, even where the row gives the expectation directly.
        predict_join(c);
        case (chk)
            CHECK_PREDICTED:
                foreach (step_results[i])
                    pending_results.push_back(step_results[i]);
            CHECK_SINGLE:
                pending_results.push_back(want);
            default:
                ;
        endcase
        if (c.opcode != nlkj_pkg::OP_NONE)
            items_sent++;
    endtask

    // Stops offering commands and waits until the engine has gone quiet, so that the
    // join mode may be changed safely.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input bit outer);
        cfg_we    <= 1'b1;
        cfg_wdata <= outer;
        @(posedge clk);
        left_outer = outer;
        cfg_we    <= 1'b0;
    endtask

    // One random batch. Most batches are well formed: an optional clear, a run of appends
    // drawn from a small pool of keys, then probes that mostly hit the pool, so that
    // duplicate keys give several matched pairs. A fill batch appends past the table's
    // capacity with a single key, giving table-full results and a 64-way match. About one
    // batch in ten is noise: arbitrary opcodes including the unused one.
    task automatic run_batch(input bit fill);
        logic [nlkj_pkg::KEY_W-1:0] pool [4];
        int               pool_n;
        int               n_app;
        int               k;
        nlkj_pkg::cmd_t   c;
        pool_n = fill ? 1 : $urandom_range(1, 4);
        for (k = 0; k < 4; k++)
        begin
            case ($urandom_range(0, 7))
                0:       pool[k] = '0;
                1:       pool[k] = '1;
                default: pool[k] = rand_key();
            endcase
        end
        if (!fill && $urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
            begin
                c.opcode    = nlkj_pkg::OP_W'($urandom_range(0, 3));
                c.key       = rand_key();
                c.probe_row = nlkj_pkg::PROW_W'($urandom_range(0, 511));
                send_cmd(c, CHECK_PREDICTED, '0);
            end
        end
        else
        begin
            if (fill || $urandom_range(0, 1) == 1)
            begin
                c = '{nlkj_pkg::OP_CLEAR, rand_key(), nlkj_pkg::PROW_W'($urandom_range(0, 511))};
                send_cmd(c, CHECK_PREDICTED, '0);
            end
            if (fill)
                n_app = $urandom_range(nlkj_pkg::BUILD_ROWS + 1, nlkj_pkg::BUILD_ROWS + 2);
            else if ($urandom_range(0, 7) == 0)
                n_app = $urandom_range(nlkj_pkg::BUILD_ROWS - 8, nlkj_pkg::BUILD_ROWS + 2);
            else
                n_app = $urandom_range(0, 8);
            repeat (n_app)
            begin
                c.opcode    = nlkj_pkg::OP_APPEND;
                c.key       = pool[$urandom_range(0, pool_n - 1)];
                c.probe_row = nlkj_pkg::PROW_W'($urandom_range(0, 511));
                send_cmd(c, CHECK_PREDICTED, '0);
            end
            repeat ($urandom_range(1, 5))
            begin
                c.opcode    = nlkj_pkg::OP_PROBE;
                c.key       = ($urandom_range(0, 6) == 0) ? rand_key()
                                                          : pool[$urandom_range(0, pool_n - 1)];
                c.probe_row = nlkj_pkg::PROW_W'($urandom_range(0, 511));
                send_cmd(c, CHECK_PREDICTED, '0);
            end
        end
    endtask

    // Result receiver: random back-pressure at the rate of the current phase, or a long
    // hold-off when the stimulus asks for one. The hold-off is counted here, in cycles,
    // while the sender keeps offering commands and the engine's queue fills up.
    always @(posedge clk)
    begin
        if (hold_asks != hold_served)
        begin
            hold_served = hold_asks;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    // Result checker: every result transfer is matched, field by field, against the
    // oldest outstanding expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status %0d left %0d right %0d",
                                          res_ch.status, res_ch.left_row, res_ch.right_row));
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              res_ch.status, want.status));
                if (res_ch.left_row !== want.left_row)
                    report_mismatch($sformatf("left_row %0d, expected %0d",
                                              res_ch.left_row, want.left_row));
                if (res_ch.right_row !== want.right_row)
                    report_mismatch($sformatf("right_row %0d, expected %0d",
                                              res_ch.right_row, want.right_row));
                if (res_ch.last !== want.last)
                    report_mismatch($sformatf("last %0d, expected %0d",
                                              res_ch.last, want.last));
            end
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transfer.
    always @(posedge clk)
    begin
        if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned send_pct [4];
        int unsigned recv_pct [4];
        int unsigned base_items;
        int          phase;

        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.opcode    = nlkj_pkg::OP_NONE;
        cmd_ch.key       = '0;
        cmd_ch.probe_row = '0;
        res_ch.ready     = 1'b0;

        // Idling per random phase: none, sender only, receiver only, both.
        send_pct = '{0, 47, 0, 33};
        recv_pct = '{0, 0, 47, 33};

        // Directed rows. Expectations that can be read straight off the behaviour are
        // written in; the multi-match probes go through the predictor.
        // Inner join, starting from reset with an empty table.
        directed.push_back(vec(1'b0, nlkj_pkg::OP_PROBE,  '0, 9'd0, CHECK_SILENT));
        directed.push_back(vec(1'b0, nlkj_pkg::OP_NONE,   '1, 9'd511, CHECK_SILENT));
        directed.push_back(vec(1'b0, nlkj_pkg::OP_APPEND, '0, 9'd0, CHECK_SINGLE,
                               nlkj_pkg::ST_APPENDED, 9'd0, 6'd0));
        directed.push_back(vec(1'b0, nlkj_pkg::OP_APPEND, '1, 9'd511, CHECK_SINGLE,
                               nlkj_pkg::ST_APPENDED, 9'd0, 6'd1));
        directed.push_back(vec(1'b0, nlkj_pkg::OP_APPEND, 64'h4142_4300_0000_0000, 9'd0,
                               CHECK_SINGLE, nlkj_pkg::ST_APPENDED, 9'd0, 6'd2));
        directed.push_back(vec(1'b0, nlkj_pkg::OP_APPEND, '0, 9'd0, CHECK_SINGLE,
                               nlkj_pkg::ST_APPENDED, 9'd0, 6'd3));
        directed.push_back(vec(1'b0, nlkj_pkg::OP_PROBE,  '0, 9'd511, CHECK_PREDICTED));
        directed.push_back(vec(1'b0, nlkj_pkg::OP_PROBE,  '1, 9'd0, CHECK_PREDICTED));
        directed.push_back(vec(1'b0, nlkj_pkg::OP_PROBE,  64'h4142_4300_0000_0000, 9'h0AA,
                               CHECK_PREDICTED));
        directed.push_back(vec(1'b0, nlkj_pkg::OP_PROBE,  64'd5, 9'h155, CHECK_SILENT));
        directed.push_back(vec(1'b0, nlkj_pkg::OP_CLEAR,  '1, 9'd511, CHECK_SILENT));
        directed.push_back(vec(1'b0, nlkj_pkg::OP_PROBE,  '0, 9'd1, CHECK_SILENT));
        directed.push_back(vec(1'b0, nlkj_pkg::OP_APPEND, 64'h5555_AAAA_5555_AAAA, 9'd0,
                               CHECK_SINGLE, nlkj_pkg::ST_APPENDED, 9'd0, 6'd0));
        // Left outer join on the same table.
        directed.push_back(vec(1'b1, nlkj_pkg::OP_PROBE,  64'd5, 9'h0AA, CHECK_SINGLE,
                               nlkj_pkg::ST_UNMATCHED, 9'h0AA, 6'd0));
        directed.push_back(vec(1'b1, nlkj_pkg::OP_PROBE,  64'h5555_AAAA_5555_AAAA, 9'd511,
                               CHECK_SINGLE, nlkj_pkg::ST_MATCHED, 9'd511, 6'd0));
        directed.push_back(vec(1'b1, nlkj_pkg::OP_APPEND, 64'hAAAA_5555_AAAA_5555, 9'd0,
                               CHECK_SINGLE, nlkj_pkg::ST_APPENDED, 9'd0, 6'd1));
        directed.push_back(vec(1'b1, nlkj_pkg::OP_PROBE,  64'hAAAA_5555_AAAA_5555, 9'h155,
                               CHECK_PREDICTED));
        directed.push_back(vec(1'b1, nlkj_pkg::OP_CLEAR,  '0, 9'd0, CHECK_SILENT));
        directed.push_back(vec(1'b1, nlkj_pkg::OP_PROBE,  '0, 9'd0, CHECK_SINGLE,
                               nlkj_pkg::ST_UNMATCHED, 9'd0, 6'd0));
        directed.push_back(vec(1'b1, nlkj_pkg::OP_NONE,   '0, 9'd0, CHECK_SILENT));
        directed.push_back(vec(1'b1, nlkj_pkg::OP_PROBE,  '1, 9'd511, CHECK_SINGLE,
                               nlkj_pkg::ST_UNMATCHED, 9'd511, 6'd0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].outer != left_outer)
            begin
                settle();
                write_mode(directed[i].outer);
            end
            send_cmd(directed[i].cmd, directed[i].chk, directed[i].want);
        end

        // Random phases, alternating between inner and left outer join. The first phase
        // opens with a long receiver hold-off during a table fill, so that the result
        // path backs up into the command queue and the engine stalls its input.
        base_items = items_sent;
        for (phase = 0; phase < 4; phase++)
        begin
            settle();
            send_idle_pct  = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            write_mode(phase[0]);
            if (phase == 0)
            begin
                hold_asks++;
                run_batch(1'b1);
            end
            while (items_sent < base_items + RANDOM_ITEMS * (phase + 1) / 4)
                run_batch(1'b0);
        end

        settle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
